// File: sv/fto_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Fenwick tree order-statistic block.
// Used by fto_alu, fto_core and fenwick_tree_order_statistic_top; depends on nothing.
package fto_pkg;

  // Field widths of the stream items and the size register.
  localparam int WORD_W      = 64;
  localparam int SIZE_W      = 11;
  localparam int OP_W        = 2;
  // Node numbers run up to twice the largest size in use.
  localparam int NODE_W      = SIZE_W + 1;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;
  localparam int IN_PAD      = IN_TDATA_W - SIZE_W - WORD_W;
  localparam int OUT_PAD     = OUT_TDATA_W - WORD_W - SIZE_W;

  // Default tree depth and the reset value of the size register.
  localparam int                DEFAULT_MAX_SIZE = 1024;
  localparam logic [SIZE_W-1:0] SIZE_RESET       = 11'd1024;

  // Operation codes carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_SUM  = 2'd1,
    OP_KTH  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // One accepted input item.
  typedef struct packed {
    op_t                op;
    logic [SIZE_W-1:0]  index;
    logic [WORD_W-1:0]  amount;
  } fto_req_t;

  // One result item.
  typedef struct packed {
    logic [WORD_W-1:0]  total;
    logic [SIZE_W-1:0]  position;
  } fto_res_t;

endpackage

// File: sv/fto_alu.sv
`timescale 1ns / 1ps
// Shared 64-bit add/subtract unit with a signed less-than flag.
// Depends on fto_pkg for the word width.
module fto_alu (
  input  logic [fto_pkg::WORD_W-1:0] a,
  input  logic [fto_pkg::WORD_W-1:0] b,
  input  logic                       sub,
  output logic [fto_pkg::WORD_W-1:0] sum,
  output logic                       lt
);

  localparam int MSB = fto_pkg::WORD_W - 1;

  logic [fto_pkg::WORD_W-1:0] b_eff;

  // One adder serves both a + b and a - b.
  assign b_eff = sub ? ~b : b;
  assign sum   = a + b_eff + {{MSB{1'b0}}, sub};

  // Signed a < b: the signs decide when they differ, else the sign of a - b.
  assign lt = (a[MSB] != b[MSB]) ? a[MSB] : sum[MSB];

endmodule

// File: sv/fto_core.sv
`timescale 1ns / 1ps
// Sequencer, tree memory and operand selection of the Fenwick tree block.
// Depends on fto_pkg and instantiates fto_alu.
module fto_core #(
  parameter int MAX_SIZE = fto_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fto_pkg::NODE_W-1:0]  live_n,
  input  logic                        start,
  input  fto_pkg::fto_req_t           req,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_take,
  output fto_pkg::fto_res_t           res
);

  localparam int AW     = $clog2(MAX_SIZE);
  localparam int NODE_W = fto_pkg::NODE_W;
  localparam int WORD_W = fto_pkg::WORD_W;
  localparam int SIZE_W = fto_pkg::SIZE_W;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_ADD_RD  = 7'b0000100,
    ST_ADD_WR  = 7'b0001000,
    ST_SUM     = 7'b0010000,
    ST_KTH_MID = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  state_t               state;
  fto_pkg::op_t         op_r;
  logic [AW-1:0]        clr_addr;
  logic [NODE_W-1:0]    node;
  logic [NODE_W-1:0]    lo1;
  logic [NODE_W-1:0]    hi;
  logic [NODE_W-1:0]    kcount;
  logic [WORD_W-1:0]    opnd;
  logic [WORD_W-1:0]    acc;
  logic                 pend;

  logic [WORD_W-1:0]    mem [MAX_SIZE];
  logic [WORD_W-1:0]    rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [WORD_W-1:0]    mem_wdata;

  logic [NODE_W-1:0]    node_m1;
  logic [NODE_W-1:0]    low_bit;
  logic [NODE_W-1:0]    node_up;
  logic [NODE_W-1:0]    req_idx;
  logic [NODE_W:0]      mid_wide;
  logic [NODE_W-1:0]    mid;
  logic                 sum_end;

  logic [WORD_W-1:0]    alu_a;
  logic [WORD_W-1:0]    alu_b;
  logic                 alu_sub;
  logic [WORD_W-1:0]    alu_sum;
  logic                 alu_lt;

  // Node arithmetic: lowest set bit, parent step and search midpoint.
  assign node_m1  = node - NODE_W'(1);
  assign low_bit  = node & (~node + NODE_W'(1));
  assign node_up  = node + low_bit;
  assign req_idx  = {1'b0, req.index};
  assign mid_wide = {1'b0, lo1} + {1'b0, hi} + (NODE_W+1)'(1);
  assign mid      = mid_wide[NODE_W:1];
  assign sum_end  = (node == '0) && !pend;

  // Shared adder: accumulate a read word, update a word, or compare to the rank.
  always_comb begin
    alu_a   = acc;
    alu_b   = rdata;
    alu_sub = 1'b0;
    if (state == ST_ADD_WR) begin
      alu_a = rdata;
      alu_b = opnd;
    end else if (state == ST_SUM && !pend) begin
      alu_b   = opnd;
      alu_sub = 1'b1;
    end
  end

  fto_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  // Memory port control: one access per cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = AW'(node_m1);
    mem_wdata = alu_sum;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (state == ST_ADD_WR) begin
      mem_we = 1'b1;
    end
  end

  // Tree word memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op_r <= req.op;
            opnd <= req.amount;
            acc  <= '0;
            pend <= 1'b0;
            case (req.op)
              fto_pkg::OP_ADD: begin
                node <= req_idx + NODE_W'(1);
                if (req_idx < live_n) begin
                  state <= ST_ADD_RD;
                end
              end
              fto_pkg::OP_SUM: begin
                node  <= (req_idx > live_n) ? live_n : req_idx;
                state <= ST_SUM;
              end
              fto_pkg::OP_KTH: begin
                lo1   <= '0;
                hi    <= live_n;
                state <= ST_KTH_MID;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_ADD_RD: begin
          state <= ST_ADD_WR;
        end
        ST_ADD_WR: begin
          node  <= node_up;
          state <= (node_up <= live_n) ? ST_ADD_RD : ST_IDLE;
        end
        ST_SUM: begin
          // Reads are issued back to back; each word is added in the cycle after its read.
          if (pend) begin
            acc <= alu_sum;
          end
          pend <= (node != '0);
          if (node != '0) begin
            node <= node - low_bit;
          end
          if (sum_end) begin
            if (op_r == fto_pkg::OP_KTH) begin
              if (alu_lt) begin
                lo1 <= kcount;
              end else begin
                hi <= kcount - NODE_W'(1);
              end
              state <= ST_KTH_MID;
            end else begin
              res.total    <= acc;
              res.position <= '0;
              state        <= ST_DONE;
            end
          end
        end
        ST_KTH_MID: begin
          if (lo1 < hi) begin
            kcount <= mid;
            node   <= mid;
            acc    <= '0;
            pend   <= 1'b0;
            state  <= ST_SUM;
          end else begin
            res.total    <= '0;
            res.position <= hi[SIZE_W-1:0];
            state        <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // The write of an update goes to the word that was read just before it.
  a_rmw_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD_WR) |-> (mem_addr == $past(mem_addr)))
    else $error("update written to a different word than was read");

  // An update only touches nodes inside the size in use.
  a_add_node: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD_RD) |-> (node != '0 && node <= live_n))
    else $error("update node outside the tree");

  // The prefix walk strictly descends toward node zero.
  a_sum_desc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM && node != '0) |=> (node < $past(node)))
    else $error("prefix walk did not descend");

  // The search window never inverts.
  a_kth_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KTH_MID) |-> (lo1 <= hi))
    else $error("search window inverted");

endmodule

// File: sv/fenwick_tree_order_statistic_top.sv
`timescale 1ns / 1ps
// Top level of the Fenwick tree order-statistic block: stream ports, size register
// and output register. Depends on fto_pkg and instantiates fto_core.

// Binary indexed tree of signed 64-bit words with add, prefix sum and kth-position
// queries, one item at a time. All words sit in a single-port memory and every
// operation walks the tree one memory access per cycle, so the word count the walk
// touches sets the time. With n the size in use and L = ceil(log2(n + 1)), an add
// reads and then writes each touched node, a prefix sum walks popcount(count) nodes,
// and a kth query runs a binary search of up to L steps, each a full prefix walk.
// After reset a clearing pass writes zero to every word, during which no input item
// is taken; size register writes are taken at any time.
// A finished result waits in the output register while the next item is taken.
module fenwick_tree_order_statistic_top #(
  parameter int MAX_SIZE = fto_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                               clk,
  input  logic                               rst,
  // Size register write.
  input  logic                               cfg_we,
  input  logic [fto_pkg::SIZE_W-1:0]         cfg_wdata,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [fto_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // index[10:0], amount[74:11]
  input  logic [fto_pkg::OP_W-1:0]           s_axis_tuser,   // op[1:0]
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [fto_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // total[63:0], position[74:64]
);

  localparam int SIZE_W = fto_pkg::SIZE_W;
  localparam int WORD_W = fto_pkg::WORD_W;
  localparam int NODE_W = fto_pkg::NODE_W;

  logic [SIZE_W-1:0]  size_reg;
  logic [NODE_W-1:0]  live_n;
  fto_pkg::fto_req_t  req;
  fto_pkg::fto_res_t  res;
  logic               core_idle;
  logic               res_valid;
  logic               res_take;
  logic               start;

  // Size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= fto_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_reg <= cfg_wdata;
    end
  end

  // The size in use is the register clamped to the tree depth.
  assign live_n = (32'(size_reg) > MAX_SIZE) ? NODE_W'(MAX_SIZE) : NODE_W'(size_reg);

  // Unpack the input transfer.
  assign req.op     = fto_pkg::op_t'(s_axis_tuser);
  assign req.index  = s_axis_tdata[SIZE_W-1:0];
  assign req.amount = s_axis_tdata[SIZE_W +: WORD_W];

  assign s_axis_tready = core_idle;
  assign start         = s_axis_tvalid && core_idle;

  fto_core #(
    .MAX_SIZE (MAX_SIZE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .live_n    (live_n),
    .start     (start),
    .req       (req),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: loads when empty or when its transfer completes.
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_axis_tdata <= {{fto_pkg::OUT_PAD{1'b0}}, res.position, res.total};
    end
  end

endmodule

// File: tb/fenwick_tree_order_statistic_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for fenwick_tree_order_statistic_top: a mirror of the tree predicts
// every prefix sum and kth answer and checks each result transfer in order.
// Depends on fto_pkg and the block's RTL only.
module fenwick_tree_order_statistic_top_test;
  import fto_pkg::*;

  localparam int DEPTH         = DEFAULT_MAX_SIZE;
  localparam int SETTLE_CYCLES = 300;
  localparam int IDLE_LIMIT    = 8000;
  localparam int PHASE_ITEMS   = 180;
  localparam int REPORT_MAX    = 10;

  // Mirror of the tree words and the size register, plus the answers still owed by the block.
  class tree_mirror;
    logic [WORD_W-1:0] words [DEPTH];
    logic [SIZE_W-1:0] size_reg;
    fto_res_t          answers [$];
    int                mismatches;
    int                checked;

    function new();
      foreach (words[k]) words[k] = '0;
      size_reg   = SIZE_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int live();
      return (size_reg > DEPTH) ? DEPTH : int'(size_reg);
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function void set_size(logic [SIZE_W-1:0] value);
      size_reg = value;
    endfunction

    // Wrapping sum of positions [0, count).
    function logic [WORD_W-1:0] prefix_total(int count);
      logic [WORD_W-1:0] acc;
      int                c;
      acc = '0;
      c   = count;
      while (c > 0) begin
        acc += words[c-1];
        c   -= c & (-c);
      end
      return acc;
    endfunction

    // Only nodes up to the current size are touched, so a later larger size sees partial sums.
    function void add_at(int pos, logic [WORD_W-1:0] delta);
      int n;
      int node;
      n = live();
      if (pos >= n) return;
      node = pos + 1;
      while (node <= n) begin
        words[node-1] += delta;
        node          += node & (-node);
      end
    endfunction

    // Smallest position whose inclusive prefix sum reaches the rank, signed compare.
    function int kth_position(logic [WORD_W-1:0] rank);
      int lo;
      int hi;
      int mid;
      lo = -1;
      hi = live();
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if ($signed(prefix_total(mid + 1)) < $signed(rank)) lo = mid;
        else hi = mid;
      end
      return hi;
    endfunction

    // Called for every accepted input transfer.
    function void note_item(op_t op, logic [SIZE_W-1:0] idx, logic [WORD_W-1:0] amt);
      fto_res_t r;
      int       cnt;
      case (op)
        OP_ADD: add_at(int'(idx), amt);
        OP_SUM: begin
          cnt        = (int'(idx) > live()) ? live() : int'(idx);
          r.total    = prefix_total(cnt);
          r.position = '0;
          answers.push_back(r);
        end
        OP_KTH: begin
          r.total    = '0;
          r.position = SIZE_W'(kth_position(amt));
          answers.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Called for every accepted result transfer.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      fto_res_t got;
      fto_res_t want;
      got.total    = data[WORD_W-1:0];
      got.position = data[WORD_W+SIZE_W-1:WORD_W];
      checked++;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with nothing expected: total=%h position=%0d",
                   $realtime, got.total, got.position);
        return;
      end
      want = answers.pop_front();
      if (got.total !== want.total || got.position !== want.position) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: mismatch: expected total=%h position=%0d, got total=%h position=%0d",
                   $realtime, want.total, want.position, got.total, got.position);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [SIZE_W-1:0]      cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  tree_mirror mirror;
  bit         steady = 1'b0;
  int         idle_cycles = 0;
  int         op_count [4] = '{0, 0, 0, 0};
  int         size_writes = 0;

  fenwick_tree_order_statistic_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transfer and stall at random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata);
      m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
      $display("fenwick_tree_order_statistic_top_test: errors");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it; tvalid stays high for a back-to-back item.
  task automatic send_item(op_t op, logic [SIZE_W-1:0] idx, logic [WORD_W-1:0] amt);
    while (!steady && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{IN_PAD{1'b0}}, amt, idx};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    mirror.note_item(op, idx, amt);
    op_count[op]++;
  endtask

  // Write the size register once the block has gone quiet.
  task automatic write_size(logic [SIZE_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_size(value);
    size_writes++;
  endtask

  // Kth rank near a real prefix sum, so the search lands on meaningful boundaries.
  function automatic logic [WORD_W-1:0] rank_near_prefix();
    logic [WORD_W-1:0] base;
    base = mirror.prefix_total($urandom_range(0, mirror.live()));
    case ($urandom_range(2))
      0:       return base - 1;
      1:       return base;
      default: return base + 1;
    endcase
  endfunction

  // Mostly well-formed traffic for an order-statistic use, with some wide noise.
  task automatic random_item();
    int                n;
    int                pick;
    logic [SIZE_W-1:0] idx;
    logic [WORD_W-1:0] amt;
    n    = mirror.live();
    pick = $urandom_range(99);
    if (pick < 40) begin
      if (n > 0 && $urandom_range(9) != 0) idx = SIZE_W'($urandom_range(0, n - 1));
      else idx = SIZE_W'($urandom);
      case ($urandom_range(19))
        0:       amt = {$urandom, $urandom};
        1, 2:    amt = 64'd0 - $urandom_range(1, 8);
        default: amt = 64'($urandom_range(0, 20));
      endcase
      send_item(OP_ADD, idx, amt);
    end else if (pick < 65) begin
      if ($urandom_range(6) != 0) idx = SIZE_W'($urandom_range(0, n));
      else idx = SIZE_W'($urandom);
      send_item(OP_SUM, idx, {$urandom, $urandom});
    end else if (pick < 95) begin
      if ($urandom_range(4) != 0) amt = rank_near_prefix();
      else amt = {$urandom, $urandom};
      send_item(OP_KTH, SIZE_W'($urandom), amt);
    end else begin
      send_item(OP_NONE, SIZE_W'($urandom), {$urandom, $urandom});
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [10];
    mirror = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tree, extremes, out-of-range adds, clamped counts, wrap, unused op.
    send_item(OP_SUM, 11'd0, '0);
    send_item(OP_SUM, 11'd1024, '0);
    send_item(OP_KTH, 11'd0, 64'd0);
    send_item(OP_KTH, 11'd0, 64'd1);
    send_item(OP_ADD, 11'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_ADD, 11'd1023, 64'h8000_0000_0000_0000);
    send_item(OP_ADD, 11'd1024, 64'd99);
    send_item(OP_ADD, 11'd2047, '1);
    send_item(OP_ADD, 11'd5, 64'd3);
    send_item(OP_ADD, 11'd512, '1);
    send_item(OP_SUM, 11'd1, '0);
    send_item(OP_SUM, 11'd6, '0);
    send_item(OP_SUM, 11'd513, '0);
    send_item(OP_SUM, 11'd1024, '0);
    send_item(OP_SUM, 11'd2047, '1);
    send_item(OP_SUM, 11'h555, '0);
    send_item(OP_KTH, 11'h7FF, 64'h8000_0000_0000_0000);
    send_item(OP_KTH, 11'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_KTH, 11'd0, 64'd1);
    send_item(OP_KTH, 11'd0, 64'h8000_0000_0000_0002);
    send_item(OP_NONE, 11'h7FF, '1);
    send_item(OP_SUM, 11'd7, '0);

    // Random phases over a spread of sizes, zero and the largest code among them.
    sizes = '{11'd1, 11'd2, 11'd0, 11'd2047, 11'd3, 11'd17, 11'd1024,
              SIZE_W'($urandom_range(1, 1024)), SIZE_W'($urandom_range(1, 64)),
              SIZE_W'($urandom_range(0, 2047))};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      steady = (p == 6);
      repeat (PHASE_ITEMS) random_item();
    end
    steady = 1'b0;

    // Drain, then allow for any result still in flight.
    s_axis_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d adds, %0d sums, %0d kth queries, %0d unused ops over %0d size writes.",
             op_count[OP_ADD], op_count[OP_SUM], op_count[OP_KTH], op_count[OP_NONE],
             size_writes);
    $display("Checked %0d results, %0d mismatches, %0d still expected.",
             mirror.checked, mirror.mismatches, mirror.pending());
    if (mirror.mismatches == 0 && mirror.pending() == 0)
      $display("fenwick_tree_order_statistic_top_test: clean");
    else
      $display("fenwick_tree_order_statistic_top_test: errors");
    $finish;
  end

endmodule
